// File: src/cpm_pkg.sv
// Shared constants and types for the comparison pattern matcher.
`timescale 1ns / 1ps
`default_nettype none
package cpm_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_PATTERN_DEF = 64;
  localparam int MIN_PATTERN_DEF = 12;

  localparam int COUNT_W = 32;
  localparam int LEN_W   = 7;
  localparam int CFG_W   = 64;
  localparam int OUT_W   = 2 * COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_RESET = 7'd12;

  // Configuration register indexes.
  localparam logic CFG_IDX_PATTERN = 1'b0;
  localparam logic CFG_IDX_LENGTH  = 1'b1;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] start;
    logic [COUNT_W-1:0] total;
  } cpm_result_t;

endpackage
`default_nettype wire

// File: src/cpm_cfg.sv
// Configuration registers with the pattern pre-aligned to the comparison history.
`timescale 1ns / 1ps
`default_nettype none
module cpm_cfg #(
  parameter int MAX_PATTERN = cpm_pkg::MAX_PATTERN_DEF,
  parameter int MIN_PATTERN = cpm_pkg::MIN_PATTERN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_index,
  input  wire logic [cpm_pkg::CFG_W-1:0]  cfg_data,
  output logic [MAX_PATTERN-1:0]          pat_align,
  output logic [MAX_PATTERN-1:0]          pat_mask,
  output logic                            len_ok,
  output logic [cpm_pkg::LEN_W-1:0]       len
);

  localparam logic RST_OK = (int'(cpm_pkg::LEN_RESET) >= MIN_PATTERN) &&
                            (int'(cpm_pkg::LEN_RESET) <= MAX_PATTERN) &&
                            (cpm_pkg::LEN_RESET != '0);
  localparam logic [MAX_PATTERN-1:0] RST_MASK =
    RST_OK ? ({MAX_PATTERN{1'b1}} << (MAX_PATTERN - int'(cpm_pkg::LEN_RESET)))
           : {MAX_PATTERN{1'b0}};
  localparam logic [cpm_pkg::LEN_W-1:0] MAX_LEN = cpm_pkg::LEN_W'(MAX_PATTERN);
  localparam logic [cpm_pkg::LEN_W-1:0] MIN_LEN = cpm_pkg::LEN_W'(MIN_PATTERN);

  logic [MAX_PATTERN-1:0]    pat_r, pat_nxt;
  logic [cpm_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [MAX_PATTERN-1:0]    align_r, align_nxt;
  logic [MAX_PATTERN-1:0]    mask_r, mask_nxt;
  logic                      ok_r, ok_nxt;
  logic [cpm_pkg::LEN_W-1:0] shift;

  always_comb begin
    pat_nxt = pat_r;
    len_nxt = len_r;
    if (cfg_valid && (cfg_index == cpm_pkg::CFG_IDX_PATTERN)) begin
      pat_nxt = cfg_data[MAX_PATTERN-1:0];
    end
    if (cfg_valid && (cfg_index == cpm_pkg::CFG_IDX_LENGTH)) begin
      len_nxt = cfg_data[cpm_pkg::LEN_W-1:0];
    end
    ok_nxt = (len_nxt >= MIN_LEN) && (len_nxt <= MAX_LEN) && (len_nxt != '0);
    // The pattern's m bits sit in the top m bits of the history.
    shift     = MAX_LEN - len_nxt;
    align_nxt = '0;
    mask_nxt  = '0;
    if (ok_nxt) begin
      align_nxt = pat_nxt << shift;
      mask_nxt  = {MAX_PATTERN{1'b1}} << shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      len_r   <= cpm_pkg::LEN_RESET;
      align_r <= '0;
      mask_r  <= RST_MASK;
      ok_r    <= RST_OK;
    end else begin
      pat_r   <= pat_nxt;
      len_r   <= len_nxt;
      align_r <= align_nxt;
      mask_r  <= mask_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign pat_align = align_r;
  assign pat_mask  = mask_r;
  assign len_ok    = ok_r;
  assign len       = len_r;

endmodule
`default_nettype wire

// File: src/cpm_match.sv
// Per-text state and the single-pass comparison and match logic.
`timescale 1ns / 1ps
`default_nettype none
module cpm_match #(
  parameter int VALUE_WIDTH = cpm_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_PATTERN = cpm_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [VALUE_WIDTH-1:0]     value,
  input  wire logic                       sot,
  input  wire logic [MAX_PATTERN-1:0]     pat_align,
  input  wire logic [MAX_PATTERN-1:0]     pat_mask,
  input  wire logic                       len_ok,
  input  wire logic [cpm_pkg::LEN_W-1:0]  len,
  output cpm_pkg::cpm_result_t            res
);

  logic [VALUE_WIDTH-1:0]      prev_r;
  logic [MAX_PATTERN-1:0]      hist_r, hist_nxt, hist_base;
  logic [cpm_pkg::COUNT_W-1:0] seen_r, seen_nxt, seen_base;
  logic [cpm_pkg::COUNT_W-1:0] found_r, found_nxt, found_base, found_inc;
  logic [cpm_pkg::COUNT_W-1:0] len_ext;
  logic                        seen_sat;
  logic                        gt;
  logic                        hit;

  always_comb begin
    seen_base  = sot ? '0 : seen_r;
    found_base = sot ? '0 : found_r;
    hist_base  = sot ? '0 : hist_r;
    len_ext    = {{(cpm_pkg::COUNT_W - cpm_pkg::LEN_W){1'b0}}, len};
    gt         = $signed(prev_r) > $signed(value);
    // The first value of a text has no predecessor to compare with.
    hist_nxt   = (seen_base != '0) ? {gt, hist_base[MAX_PATTERN-1:1]} : hist_base;
    seen_sat   = (seen_base == cpm_pkg::COUNT_MAX);
    seen_nxt   = seen_sat ? seen_base : seen_base + 1'b1;
    found_inc  = (found_base == cpm_pkg::COUNT_MAX) ? found_base : found_base + 1'b1;
    // seen_base >= m is the same test as the updated count reaching m+1.
    hit        = len_ok && (seen_base >= len_ext) &&
                 (((hist_nxt ^ pat_align) & pat_mask) == '0);
    found_nxt  = hit ? found_inc : found_base;
    res.hit    = hit;
    res.start  = seen_base - len_ext - {{(cpm_pkg::COUNT_W - 1){1'b0}}, seen_sat};
    res.total  = found_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      hist_r  <= '0;
      seen_r  <= '0;
      found_r <= '0;
    end else if (step) begin
      prev_r  <= value;
      hist_r  <= hist_nxt;
      seen_r  <= seen_nxt;
      found_r <= found_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/comparison_pattern_matcher_core.sv
// Datapath: an accepted item is held in the input register and, when it moves on, a
// matching item's result is loaded into the result register and offered from there.
// Throughput: one item per cycle; the input register and the result register each
// hold one item, and the input side stalls only while a result waits untaken.
// Reset: synchronous active-low rst_n clears history, counters and handshake state,
// and loads pattern 0 with length 12.
`timescale 1ns / 1ps
`default_nettype none
module comparison_pattern_matcher_core #(
  parameter int VALUE_WIDTH = cpm_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_PATTERN = cpm_pkg::MAX_PATTERN_DEF,
  parameter int MIN_PATTERN = cpm_pkg::MIN_PATTERN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]  in_tdata,   // text_value
  input  wire logic                              in_tuser,   // start_of_text
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cpm_pkg::OUT_W-1:0]              out_tdata,  // match_total (upper), match_start (lower)
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [cpm_pkg::CFG_W-1:0]         cfg_data
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic [VALUE_WIDTH-1:0]    s1_value_r;
  logic                      s1_sot_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [cpm_pkg::OUT_W-1:0] out_data_r;
  logic                      proceed;
  logic                      in_xfer;
  logic [MAX_PATTERN-1:0]    pat_align;
  logic [MAX_PATTERN-1:0]    pat_mask;
  logic                      len_ok;
  logic [cpm_pkg::LEN_W-1:0] len;
  cpm_pkg::cpm_result_t      res;

  cpm_cfg #(
    .MAX_PATTERN(MAX_PATTERN),
    .MIN_PATTERN(MIN_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_align (pat_align),
    .pat_mask  (pat_mask),
    .len_ok    (len_ok),
    .len       (len)
  );

  cpm_match #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proceed),
    .value     (s1_value_r),
    .sot       (s1_sot_r),
    .pat_align (pat_align),
    .pat_mask  (pat_mask),
    .len_ok    (len_ok),
    .len       (len),
    .res       (res)
  );

  // The registered item moves on whenever the result register is free or draining.
  assign proceed   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proceed;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = in_xfer || (s1_valid_r && !proceed);
    if (proceed) begin
      out_valid_nxt = res.hit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_value_r <= in_tdata[VALUE_WIDTH-1:0];
      s1_sot_r   <= in_tuser;
    end
    if (proceed && res.hit) begin
      out_data_r <= {res.total, res.start};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: src/cpm_checker.sv
// Port-level checks for the comparison pattern matcher and their bind.
`timescale 1ns / 1ps
`default_nettype none
module cpm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [cpm_pkg::OUT_W-1:0]     out_tdata
);

  // A rise of out_tvalid must be preceded by an input transfer.
  a_rise_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result offered without a matching input transfer");

  // Every reported match counts itself.
  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[cpm_pkg::OUT_W-1:cpm_pkg::COUNT_W] != '0))
    else $error("match_total is zero on a reported match");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result withdrawn before transfer");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind comparison_pattern_matcher_core cpm_checker u_cpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
